// ===== sv/bhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bhsl_pkg
// shared widths, codes and types for the button hold / status led controller
// ----------------------------------------------------------------------------
`default_nettype none

package bhsl_pkg;

	localparam int TIMER_BITS = 16;
	localparam int STEP_BITS  = 14;
	localparam int PERIOD_BITS = 10;
	localparam int LIMIT_BITS  = 16;

	localparam logic [STEP_BITS-1:0] STEP_WRAP = STEP_BITS'(10000);
	localparam logic [TIMER_BITS-1:0] HOLD_MAX = {TIMER_BITS{1'b1}};

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_SLOW   = 2'd1;
	localparam logic [1:0] MODE_FAST   = 2'd2;
	localparam logic [1:0] MODE_ROTATE = 2'd3;

	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_SHORT    = 3'd1;
	localparam logic [2:0] REG_LONG     = 3'd2;
	localparam logic [2:0] REG_NORMAL   = 3'd3;
	localparam logic [2:0] REG_SLOW     = 3'd4;
	localparam logic [2:0] REG_FAST     = 3'd5;
	localparam logic [2:0] REG_ROTATE   = 3'd6;

	typedef struct packed {
		logic [PERIOD_BITS-1:0] debounce_ms;
		logic [LIMIT_BITS-1:0]  short_limit_ms;
		logic [LIMIT_BITS-1:0]  long_limit_ms;
		logic [PERIOD_BITS-1:0] normal_period_ms;
		logic [PERIOD_BITS-1:0] slow_period_ms;
		logic [PERIOD_BITS-1:0] fast_period_ms;
		logic [PERIOD_BITS-1:0] rotate_period_ms;
	} cfg_t;

	typedef struct packed {
		logic       clear_config;
		logic       ota_start;
		logic [1:0] mode;
	} btn_res_t;

endpackage

`default_nettype wire

// ===== sv/button_hold_status_led_controller.sv =====
// ----------------------------------------------------------------------------
// button_hold_status_led_controller
// long-press button detector with status led driver, one item per ms tick
// ----------------------------------------------------------------------------
// usage:
//  - each input transfer is one millisecond tick: raw button level plus link
//    status; each tick gives exactly one output transfer with the led levels,
//    the clear_config / ota_start pulses and the current led mode
//  - an input transfer lands in an input register; from there the tick is
//    evaluated and its result written to the output register, which sets
//    out_valid; the output transfer is taken from the output register
//  - throughput is one tick per cycle while out_ready is high; the limit is
//    the single output register, which is reloaded in the cycle it is taken
//  - when the receiver stalls, the output holds, the input register fills and
//    in_ready drops until out_ready returns
//  - configuration writes (cfg_index 0..6) are always accepted and should be
//    made only while no tick is in flight; index 7 is ignored
//  - reset clears all state to idle / normal mode, leds all high, and restores
//    the default register values; the first tick runs an led step
// ----------------------------------------------------------------------------
`default_nettype none

module button_hold_status_led_controller
	import bhsl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        button_level,
	input  wire logic        wifi_up,
	input  wire logic        ethernet_up,
	input  wire logic [7:0]  ble_links,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        led_one,
	output      logic        led_two,
	output      logic        led_three,
	output      logic        clear_config,
	output      logic        ota_start,
	output      logic [1:0]  led_mode,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       level_s1, wifi_s1, eth_s1;
	logic [7:0] ble_s1;
	logic       adv;
	btn_res_t   btn_res;
	logic [2:0] leds;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= PERIOD_BITS'(300);
			cfg_q.short_limit_ms   <= LIMIT_BITS'(3000);
			cfg_q.long_limit_ms    <= LIMIT_BITS'(8000);
			cfg_q.normal_period_ms <= PERIOD_BITS'(800);
			cfg_q.slow_period_ms   <= PERIOD_BITS'(500);
			cfg_q.fast_period_ms   <= PERIOD_BITS'(100);
			cfg_q.rotate_period_ms <= PERIOD_BITS'(300);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms      <= cfg_data[PERIOD_BITS-1:0];
				REG_SHORT:    cfg_q.short_limit_ms   <= cfg_data[LIMIT_BITS-1:0];
				REG_LONG:     cfg_q.long_limit_ms    <= cfg_data[LIMIT_BITS-1:0];
				REG_NORMAL:   cfg_q.normal_period_ms <= cfg_data[PERIOD_BITS-1:0];
				REG_SLOW:     cfg_q.slow_period_ms   <= cfg_data[PERIOD_BITS-1:0];
				REG_FAST:     cfg_q.fast_period_ms   <= cfg_data[PERIOD_BITS-1:0];
				REG_ROTATE:   cfg_q.rotate_period_ms <= cfg_data[PERIOD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// tick moves from input register to output register
	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= button_level;
			wifi_s1  <= wifi_up;
			eth_s1   <= ethernet_up;
			ble_s1   <= ble_links;
		end
	end

	bhsl_button u_button (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.button_level (level_s1),
		.cfg          (cfg_q),
		.res          (btn_res)
	);

	bhsl_led u_led (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.mode        (btn_res.mode),
		.wifi_up     (wifi_s1),
		.ethernet_up (eth_s1),
		.ble_links   (ble_s1),
		.cfg         (cfg_q),
		.leds        (leds)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			led_one      <= leds[0];
			led_two      <= leds[1];
			led_three    <= leds[2];
			clear_config <= btn_res.clear_config;
			ota_start    <= btn_res.ota_start;
			led_mode     <= btn_res.mode;
		end
	end

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(clear_config && ota_start))
		else $error("clear and update pulses together");

	a_clear_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clear_config) |-> (led_mode == MODE_NORMAL))
		else $error("clear pulse without normal mode");

	a_ota_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ota_start) |-> (led_mode == MODE_ROTATE))
		else $error("update pulse without rotate mode");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |=> valid_s1)
		else $error("input register lost a tick during stall");

endmodule

`default_nettype wire

// ===== sv/bhsl_button.sv =====
// ----------------------------------------------------------------------------
// bhsl_button
// debounce, hold counting and mode selection, one tick per enable
// ----------------------------------------------------------------------------
`default_nettype none

module bhsl_button
	import bhsl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     button_level,
	input  wire cfg_t     cfg,
	output      btn_res_t res
);

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_HOLD     = 2'd2;

	logic [1:0]            phase_q, phase_d;
	logic [TIMER_BITS-1:0] ticks_q, ticks_d, ticks_inc;
	logic [1:0]            mode_q, mode_d;
	logic                  clr_d, ota_d;

	assign ticks_inc = ticks_q + TIMER_BITS'(1);

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		mode_d  = mode_q;
		clr_d   = 1'b0;
		ota_d   = 1'b0;
		case (phase_q)
			PH_DEBOUNCE: begin
				ticks_d = ticks_inc;
				if (ticks_inc >= TIMER_BITS'(cfg.debounce_ms)) begin
					ticks_d = '0;
					phase_d = button_level ? PH_IDLE : PH_HOLD;
				end
			end
			PH_HOLD: begin
				if (button_level) begin
					if (ticks_q >= cfg.short_limit_ms && ticks_q < cfg.long_limit_ms) begin
						clr_d  = 1'b1;
						mode_d = MODE_NORMAL;
					end else if (ticks_q >= cfg.long_limit_ms) begin
						ota_d  = 1'b1;
						mode_d = MODE_ROTATE;
					end
					phase_d = PH_IDLE;
					ticks_d = '0;
				end else if (ticks_q != HOLD_MAX) begin
					ticks_d = ticks_inc;
					if (ticks_inc == cfg.short_limit_ms) mode_d = MODE_SLOW;
					if (ticks_inc == cfg.long_limit_ms) mode_d = MODE_FAST;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (!button_level) begin
					ticks_d = '0;
					phase_d = (cfg.debounce_ms == '0) ? PH_HOLD : PH_DEBOUNCE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			mode_q  <= MODE_NORMAL;
		end else if (en) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			mode_q  <= mode_d;
		end
	end

	assign res.clear_config = clr_d;
	assign res.ota_start    = ota_d;
	assign res.mode         = mode_d;

endmodule

`default_nettype wire

// ===== sv/bhsl_led.sv =====
// ----------------------------------------------------------------------------
// bhsl_led
// led step timer, step counter with phases, and led pattern per mode
// ----------------------------------------------------------------------------
`default_nettype none

module bhsl_led
	import bhsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [1:0] mode,
	input  wire logic       wifi_up,
	input  wire logic       ethernet_up,
	input  wire logic [7:0] ble_links,
	input  wire cfg_t       cfg,
	output      logic [2:0] leds
);

	logic [PERIOD_BITS-1:0] timer_q, timer_d, period;
	logic [STEP_BITS-1:0]   count_q, count_d;
	logic [1:0]             mod3_q, mod3_d;
	logic                   blink_q, blink_d;
	logic [1:0]             rot_q, rot_d;
	logic [2:0]             leds_q, leds_d;
	logic                   l3;

	always_comb begin
		case (mode)
			MODE_NORMAL: period = cfg.normal_period_ms;
			MODE_SLOW:   period = cfg.slow_period_ms;
			MODE_FAST:   period = cfg.fast_period_ms;
			default:     period = cfg.rotate_period_ms;
		endcase
	end

	always_comb begin
		timer_d = timer_q - PERIOD_BITS'(1);
		count_d = count_q;
		mod3_d  = mod3_q;
		blink_d = blink_q;
		rot_d   = rot_q;
		leds_d  = leds_q;
		l3      = 1'b0;
		if (timer_q == '0) begin
			timer_d = (period == '0) ? '0 : period - PERIOD_BITS'(1);
			if (count_q == STEP_WRAP) begin
				count_d = '0;
				mod3_d  = 2'd0;
			end else begin
				count_d = count_q + STEP_BITS'(1);
				mod3_d  = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
				blink_d = count_d[0];
				rot_d   = mod3_d;
			end
			case (mode)
				MODE_NORMAL: begin
					l3     = wifi_up ? blink_d : !ethernet_up;
					leds_d = {l3, (ble_links == '0), 1'b0};
				end
				MODE_SLOW, MODE_FAST: leds_d = {3{blink_d}};
				default: begin
					case (rot_d)
						2'd0:    leds_d = 3'b110;
						2'd1:    leds_d = 3'b101;
						2'd2:    leds_d = 3'b011;
						default: leds_d = leds_q;
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			count_q <= '0;
			mod3_q  <= 2'd0;
			blink_q <= 1'b0;
			rot_q   <= 2'd0;
			leds_q  <= 3'b111;
		end else if (en) begin
			timer_q <= timer_d;
			count_q <= count_d;
			mod3_q  <= mod3_d;
			blink_q <= blink_d;
			rot_q   <= rot_d;
			leds_q  <= leds_d;
		end
	end

	assign leds = leds_d;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the button hold / status led controller: ticks are
// driven through the input valid/ready channel, each accepted tick is run
// through a cycle-free prediction of the button and led logic, and every
// output transfer is compared field by field against the oldest prediction;
// directed ticks first, then random press sequences over several settings
// ----------------------------------------------------------------------------
module tb_top;
	import bhsl_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef enum logic [1:0] {
		BTN_IDLE     = 2'd0,
		BTN_DEBOUNCE = 2'd1,
		BTN_HOLD     = 2'd2
	} btn_phase_e;

	typedef struct packed {
		logic       led_one;
		logic       led_two;
		logic       led_three;
		logic       clear_config;
		logic       ota_start;
		logic [1:0] led_mode;
	} led_result_t;

	class status_scoreboard;
		cfg_t                cfg;
		btn_phase_e          phase;
		logic [15:0]         hold_ticks;
		logic [1:0]          mode;
		logic [9:0]          step_timer;
		logic [13:0]         step_count;
		logic                blink;
		logic [1:0]          rot;
		logic [2:0]          leds;
		led_result_t         pending_results[$];
		int                  failures;

		function new();
			cfg = '{debounce_ms: 10'd300, short_limit_ms: 16'd3000, long_limit_ms: 16'd8000,
				normal_period_ms: 10'd800, slow_period_ms: 10'd500,
				fast_period_ms: 10'd100, rotate_period_ms: 10'd300};
			phase = BTN_IDLE;
			hold_ticks = '0;
			mode = MODE_NORMAL;
			step_timer = '0;
			step_count = '0;
			blink = 1'b0;
			rot = '0;
			leds = 3'b111;
			failures = 0;
		endfunction

		function void configure(logic [2:0] idx, logic [15:0] data);
			case (idx)
			REG_DEBOUNCE: cfg.debounce_ms = data[9:0];
			REG_SHORT: cfg.short_limit_ms = data;
			REG_LONG: cfg.long_limit_ms = data;
			REG_NORMAL: cfg.normal_period_ms = data[9:0];
			REG_SLOW: cfg.slow_period_ms = data[9:0];
			REG_FAST: cfg.fast_period_ms = data[9:0];
			REG_ROTATE: cfg.rotate_period_ms = data[9:0];
			default: ;
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_tick(logic lvl, logic wifi, logic eth, logic [7:0] ble);
			led_result_t r;
			logic [9:0]  per;
			r = '0;
			case (phase)
			BTN_DEBOUNCE: begin
				hold_ticks = hold_ticks + 1'b1;
				if (hold_ticks >= {6'd0, cfg.debounce_ms}) begin
					hold_ticks = '0;
					phase = lvl ? BTN_IDLE : BTN_HOLD;
				end
			end
			BTN_HOLD: begin
				if (lvl) begin
					if (hold_ticks >= cfg.short_limit_ms && hold_ticks < cfg.long_limit_ms) begin
						r.clear_config = 1'b1;
						mode = MODE_NORMAL;
					end else if (hold_ticks >= cfg.long_limit_ms) begin
						r.ota_start = 1'b1;
						mode = MODE_ROTATE;
					end
					phase = BTN_IDLE;
					hold_ticks = '0;
				end else if (hold_ticks != HOLD_MAX) begin
					hold_ticks = hold_ticks + 1'b1;
					if (hold_ticks == cfg.short_limit_ms) mode = MODE_SLOW;
					if (hold_ticks == cfg.long_limit_ms) mode = MODE_FAST;
				end
			end
			default: begin
				phase = BTN_IDLE;
				if (!lvl) begin
					hold_ticks = '0;
					phase = (cfg.debounce_ms == '0) ? BTN_HOLD : BTN_DEBOUNCE;
				end
			end
			endcase

			if (step_timer == '0) begin
				// wrap step keeps both phases
				if (step_count == STEP_WRAP) begin
					step_count = '0;
				end else begin
					step_count = step_count + 1'b1;
					blink = step_count[0];
					rot = 2'(step_count % 14'd3);
				end
				case (mode)
				MODE_NORMAL: leds = {wifi ? blink : ~eth, ble == 8'd0, 1'b0};
				MODE_SLOW, MODE_FAST: leds = {3{blink}};
				default: begin
					case (rot)
					2'd0: leds = 3'b110;
					2'd1: leds = 3'b101;
					2'd2: leds = 3'b011;
					default: ;
					endcase
				end
				endcase
				case (mode)
				MODE_NORMAL: per = cfg.normal_period_ms;
				MODE_SLOW: per = cfg.slow_period_ms;
				MODE_FAST: per = cfg.fast_period_ms;
				default: per = cfg.rotate_period_ms;
				endcase
				step_timer = (per == '0) ? '0 : per - 1'b1;
			end else begin
				step_timer = step_timer - 1'b1;
			end

			r.led_one = leds[0];
			r.led_two = leds[1];
			r.led_three = leds[2];
			r.led_mode = mode;
			pending_results.push_back(r);
		endfunction

		function void check_tick(led_result_t got);
			led_result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: tick result with none outstanding: %p", $time, got);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("%0t: tick result mismatch: expected %p, got %p", $time, want, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        button_level;
	logic        wifi_up;
	logic        ethernet_up;
	logic [7:0]  ble_links;
	logic        out_valid;
	logic        out_ready;
	logic        led_one;
	logic        led_two;
	logic        led_three;
	logic        clear_config;
	logic        ota_start;
	logic [1:0]  led_mode;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	status_scoreboard sb;
	bit               calm = 1'b0;
	bit               long_hold_req = 1'b0;
	int               ticks_sent = 0;
	int unsigned      cycle_count = 0;

	button_hold_status_led_controller i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_tick({led_one, led_two, led_three, clear_config, ota_start, led_mode});
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_ble();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 8'd0;
		if (r == 3) return 8'hFF;
		return 8'($urandom_range(1, 254));
	endfunction

	function automatic logic [9:0] pick_period();
		if ($urandom_range(0, 9) == 0) return 10'd1023;
		return 10'($urandom_range(0, 5));
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.debounce_ms = 10'($urandom_range(0, 6));
		c.short_limit_ms = 16'($urandom_range(0, 20));
		c.long_limit_ms = 16'($urandom_range(0, 40));
		c.normal_period_ms = pick_period();
		c.slow_period_ms = pick_period();
		c.fast_period_ms = pick_period();
		c.rotate_period_ms = pick_period();
		return c;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (1 + pick_gap()) @(posedge clk);
			end
		end
	end

	task automatic send_tick(input logic lvl, input logic wifi, input logic eth,
			input logic [7:0] ble);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_level <= lvl;
		wifi_up <= wifi;
		ethernet_up <= eth;
		ble_links <= ble;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(lvl, wifi, eth, ble);
		ticks_sent++;
	endtask

	task automatic rand_tick(input logic lvl);
		send_tick(lvl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_ble());
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.configure(idx, data);
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_DEBOUNCE, {6'($urandom), c.debounce_ms});
		write_reg(REG_SHORT, c.short_limit_ms);
		write_reg(REG_LONG, c.long_limit_ms);
		write_reg(REG_NORMAL, {6'($urandom), c.normal_period_ms});
		write_reg(REG_SLOW, {6'($urandom), c.slow_period_ms});
		write_reg(REG_FAST, {6'($urandom), c.fast_period_ms});
		write_reg(REG_ROTATE, {6'($urandom), c.rotate_period_ms});
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one press: idle ticks, then a clean hold near the limits, bounce noise,
	// or a release during or right after the debounce
	task automatic press_sequence();
		int kind;
		int hold;
		int lo;
		int hi;
		kind = $urandom_range(0, 99);
		lo = int'(sb.cfg.short_limit_ms);
		hi = int'(sb.cfg.long_limit_ms);
		repeat ($urandom_range(0, 4)) rand_tick(1'b1);
		if (kind < 75) begin
			case ($urandom_range(0, 5))
			0: hold = lo - 1;
			1: hold = lo;
			2: hold = hi - 1;
			3: hold = hi;
			4: hold = hi + $urandom_range(1, 6);
			default: hold = $urandom_range(0, hi + 4);
			endcase
			if (hold < 0) hold = 0;
			repeat (1 + int'(sb.cfg.debounce_ms) + hold) rand_tick(1'b0);
			rand_tick(1'b1);
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 12)) rand_tick(1'($urandom_range(0, 1)));
		end else begin
			repeat ($urandom_range(1, int'(sb.cfg.debounce_ms) + 1)) rand_tick(1'b0);
			rand_tick(1'b1);
		end
	endtask

	initial begin
		cfg_t c;
		int   stop_at;
		arst_n = 1'b0;
		in_valid = 1'b0;
		button_level = 1'b1;
		wifi_up = 1'b0;
		ethernet_up = 1'b0;
		ble_links = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, then tight limits with every mode reached
		send_tick(1'b1, 1'b1, 1'b1, 8'hFF);
		drain();
		write_reg(REG_SPARE, 16'hFFFF);
		c = '{debounce_ms: 10'd0, short_limit_ms: 16'd1, long_limit_ms: 16'd2,
			normal_period_ms: 10'd0, slow_period_ms: 10'd1, fast_period_ms: 10'd1,
			rotate_period_ms: 10'd1};
		load_config(c);
		send_tick(1'b1, 1'b1, 1'b0, 8'd1);
		send_tick(1'b1, 1'b0, 1'b1, 8'd0);
		send_tick(1'b1, 1'b0, 1'b0, 8'd128);
		send_tick(1'b1, 1'b1, 1'b1, 8'd0);
		send_tick(1'b0, 1'b1, 1'b1, 8'hFF);
		rand_tick(1'b1);
		repeat (2) rand_tick(1'b0);
		rand_tick(1'b1);
		repeat (4) rand_tick(1'b0);
		repeat (4) rand_tick(1'b1);
		drain();
		// equal limits, release during debounce
		c = '{debounce_ms: 10'd2, short_limit_ms: 16'd3, long_limit_ms: 16'd3,
			normal_period_ms: 10'd1023, slow_period_ms: 10'd2, fast_period_ms: 10'd3,
			rotate_period_ms: 10'd0};
		load_config(c);
		rand_tick(1'b0);
		repeat (2) rand_tick(1'b1);
		repeat (6) rand_tick(1'b0);
		rand_tick(1'b1);

		// random settings and press sequences
		for (int p = 0; p < 6; p++) begin
			drain();
			load_config(random_cfg());
			calm = (p == 3);
			if (p == 2) long_hold_req = 1'b1;
			stop_at = ticks_sent + 250;
			while (ticks_sent < stop_at) press_sequence();
		end
		calm = 1'b0;

		drain();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
